### rtl/core/bac_pkg.sv
// Shared types and constants for the BCD alarm clock core.
// No dependencies; compile first.
package bac_pkg;

    localparam int unsigned TPS_W          = 16;
    localparam int unsigned TPS_RESET      = 1000;
    localparam int unsigned MINUTES_PER_DAY = 1440;
    localparam int unsigned MOD_W          = 11;   // minute of day, reduced
    localparam int unsigned RAW_MIN_W      = 12;   // minute of day from raw digits

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_TIME = 3'd1,
        CMD_SET_ALRM = 3'd2,
        CMD_DISABLE  = 3'd3,
        CMD_SNOOZE   = 3'd4,
        CMD_CANCEL   = 3'd5
    } t_cmd;

    typedef logic [TPS_W-1:0] t_tps;

    typedef struct packed {
        logic [2:0] cmd;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [7:0] snooze_minutes;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       out_hour_tens;
        logic [3:0]       out_hour_units;
        logic [2:0]       out_minute_tens;
        logic [3:0]       out_minute_units;
        logic [2:0]       out_second_tens;
        logic [3:0]       out_second_units;
        logic             time_valid;
        logic [TPS_W-1:0] tick_count;
        logic             alarm_fire;
        logic             alarm_stop;
        logic             alarm_enabled;
    } t_out_word;

endpackage

### rtl/core/bac_chan_if.sv
// Valid/ready channel carrying one word of any payload type.
// Payload types come from bac_pkg.
interface bac_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/bcd_alarm_clock_core.sv
// Top level of the BCD alarm clock: time keeping, alarm match and result register.
// Depends on bac_pkg and bac_chan_if.

// 24-hour clock held as six BCD digits with a tick prescaler and one alarm with
// snooze. Each command word on i_cmd_ch produces exactly one result word on
// o_res_ch holding the clock state after that command. Throughput is one word
// per cycle: the whole update is a single combinational pass from the current
// state registers into the next state and the result register, and the result
// register frees itself in the same cycle it is drained, so a new command is
// taken whenever the result slot is empty or being read. The result word is
// registered on accept and is valid in the cycle after. The alarm target (alarm
// minute plus snooze offset, modulo one day) is kept in its own register so a
// tick only compares against it. Write ticks_per_second on i_cfg_ch only while
// the block is idle; a value of zero behaves as one.
module bcd_alarm_clock_core
    import bac_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    bac_chan_if.sink    i_cfg_ch,
    bac_chan_if.sink    i_cmd_ch,
    bac_chan_if.source  o_res_ch
);

    // Minute of day from raw digits, no reduction.
    function automatic logic [RAW_MIN_W-1:0] minute_of(
        input logic [1:0] ht, input logic [3:0] hu,
        input logic [2:0] mt, input logic [3:0] mu);
        logic [5:0] hours;
        hours = 6'(ht) * 6'd10 + 6'(hu);
        return RAW_MIN_W'(hours) * RAW_MIN_W'(60) + RAW_MIN_W'(mt) * RAW_MIN_W'(10)
               + RAW_MIN_W'(mu);
    endfunction

    // Reduce a sum below three days' worth of minutes into one day.
    function automatic logic [MOD_W-1:0] reduce_day(input logic [RAW_MIN_W:0] v);
        logic [RAW_MIN_W:0] r;
        if (v >= (RAW_MIN_W+1)'(2 * MINUTES_PER_DAY)) begin
            r = v - (RAW_MIN_W+1)'(2 * MINUTES_PER_DAY);
        end else if (v >= (RAW_MIN_W+1)'(MINUTES_PER_DAY)) begin
            r = v - (RAW_MIN_W+1)'(MINUTES_PER_DAY);
        end else begin
            r = v;
        end
        return r[MOD_W-1:0];
    endfunction

    // Configuration
    t_tps r_tps;

    // Clock state
    logic [1:0]       r_h1, n_h1;
    logic [3:0]       r_h0, n_h0;
    logic [2:0]       r_m1, n_m1;
    logic [3:0]       r_m0, n_m0;
    logic [2:0]       r_s1, n_s1;
    logic [3:0]       r_s0, n_s0;
    logic             r_tvalid, n_tvalid;
    logic [TPS_W-1:0] r_presc, n_presc;

    // Alarm state
    logic [1:0]       r_ah1, n_ah1;
    logic [3:0]       r_ah0, n_ah0;
    logic [2:0]       r_am1, n_am1;
    logic [3:0]       r_am0, n_am0;
    logic             r_en, n_en;
    logic [MOD_W-1:0] r_offset, n_offset;
    logic [MOD_W-1:0] r_target, n_target;

    // Result slot
    logic             r_out_valid;
    t_out_word        r_out;

    logic             fire, stop;
    logic             accept;
    t_in_word         cmd_w;
    t_tps             period;
    logic [TPS_W:0]   tick_next;
    logic [MOD_W:0]   snooze_sum;

    assign cmd_w           = i_cmd_ch.data;
    assign i_cfg_ch.ready  = 1'b1;
    assign i_cmd_ch.ready  = !r_out_valid || o_res_ch.ready;
    assign accept          = i_cmd_ch.valid && i_cmd_ch.ready;
    assign o_res_ch.valid  = r_out_valid;
    assign o_res_ch.data   = r_out;

    assign period     = (r_tps == '0) ? TPS_W'(1) : r_tps;
    assign tick_next  = {1'b0, r_presc} + (TPS_W+1)'(1);
    assign snooze_sum = {1'b0, r_offset} + (MOD_W+1)'(cmd_w.snooze_minutes);

    always_comb begin
        n_h1 = r_h1;  n_h0 = r_h0;  n_m1 = r_m1;  n_m0 = r_m0;
        n_s1 = r_s1;  n_s0 = r_s0;
        n_tvalid = r_tvalid;
        n_presc  = r_presc;
        n_ah1 = r_ah1;  n_ah0 = r_ah0;  n_am1 = r_am1;  n_am0 = r_am0;
        n_en     = r_en;
        n_offset = r_offset;
        fire = 1'b0;
        stop = 1'b0;

        case (cmd_w.cmd)
            CMD_TICK: begin
                if (tick_next >= {1'b0, period}) begin
                    n_presc = '0;
                    // Advance one second with BCD carries; out-of-range digits
                    // carry as soon as they reach the roll-over value.
                    if (r_s0 < 4'd9) begin
                        n_s0 = r_s0 + 4'd1;
                    end else begin
                        n_s0 = '0;
                        if (r_s1 < 3'd5) begin
                            n_s1 = r_s1 + 3'd1;
                        end else begin
                            n_s1 = '0;
                            if (r_m0 < 4'd9) begin
                                n_m0 = r_m0 + 4'd1;
                            end else begin
                                n_m0 = '0;
                                if (r_m1 < 3'd5) begin
                                    n_m1 = r_m1 + 3'd1;
                                end else begin
                                    n_m1 = '0;
                                    if (r_h1 >= 2'd2 && r_h0 >= 4'd3) begin
                                        n_h1 = '0;
                                        n_h0 = '0;
                                    end else if (r_h0 >= 4'd9) begin
                                        n_h0 = '0;
                                        n_h1 = r_h1 + 2'd1;
                                    end else begin
                                        n_h0 = r_h0 + 4'd1;
                                    end
                                end
                            end
                        end
                    end
                    // Check the alarm only when the second lands on a new minute.
                    if (n_s1 == '0 && n_s0 == '0 && r_en &&
                        minute_of(n_h1, n_h0, n_m1, n_m0) == RAW_MIN_W'(r_target)) begin
                        fire = 1'b1;
                    end
                end else begin
                    n_presc = tick_next[TPS_W-1:0];
                end
            end
            CMD_SET_TIME: begin
                n_h1 = cmd_w.hour_tens;    n_h0 = cmd_w.hour_units;
                n_m1 = cmd_w.minute_tens;  n_m0 = cmd_w.minute_units;
                n_s1 = cmd_w.second_tens;  n_s0 = cmd_w.second_units;
                n_tvalid = 1'b1;
            end
            CMD_SET_ALRM: begin
                n_ah1 = cmd_w.hour_tens;    n_ah0 = cmd_w.hour_units;
                n_am1 = cmd_w.minute_tens;  n_am0 = cmd_w.minute_units;
                n_en  = 1'b1;
            end
            CMD_DISABLE: begin
                n_en     = 1'b0;
                n_offset = '0;
            end
            CMD_SNOOZE: begin
                // Sum stays below two days, so one subtract reduces it.
                if (snooze_sum >= (MOD_W+1)'(MINUTES_PER_DAY)) begin
                    n_offset = MOD_W'(snooze_sum - (MOD_W+1)'(MINUTES_PER_DAY));
                end else begin
                    n_offset = snooze_sum[MOD_W-1:0];
                end
                stop = 1'b1;
            end
            CMD_CANCEL: begin
                n_offset = '0;
                stop     = 1'b1;
            end
            default: begin
                // Unused codes: hold everything.
            end
        endcase

        // Track the alarm target from the alarm digits and offset being stored.
        n_target = reduce_day((RAW_MIN_W+1)'(minute_of(n_ah1, n_ah0, n_am1, n_am0))
                              + (RAW_MIN_W+1)'(n_offset));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_W'(TPS_RESET);
        end else if (i_cfg_ch.valid && i_cfg_ch.ready) begin
            r_tps <= i_cfg_ch.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;  r_h0 <= '0;  r_m1 <= '0;  r_m0 <= '0;
            r_s1 <= '0;  r_s0 <= '0;
            r_tvalid <= 1'b0;
            r_presc  <= '0;
            r_ah1 <= '0;  r_ah0 <= '0;  r_am1 <= '0;  r_am0 <= '0;
            r_en     <= 1'b0;
            r_offset <= '0;
            r_target <= '0;
        end else if (accept) begin
            r_h1 <= n_h1;  r_h0 <= n_h0;  r_m1 <= n_m1;  r_m0 <= n_m0;
            r_s1 <= n_s1;  r_s0 <= n_s0;
            r_tvalid <= n_tvalid;
            r_presc  <= n_presc;
            r_ah1 <= n_ah1;  r_ah0 <= n_ah0;  r_am1 <= n_am1;  r_am0 <= n_am0;
            r_en     <= n_en;
            r_offset <= n_offset;
            r_target <= n_target;
        end
    end

    // Result slot: fill on accept, drop once the sink takes the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.out_hour_tens    <= n_h1;
            r_out.out_hour_units   <= n_h0;
            r_out.out_minute_tens  <= n_m1;
            r_out.out_minute_units <= n_m0;
            r_out.out_second_tens  <= n_s1;
            r_out.out_second_units <= n_s0;
            r_out.time_valid       <= n_tvalid;
            r_out.tick_count       <= n_presc;
            r_out.alarm_fire       <= fire;
            r_out.alarm_stop       <= stop;
            r_out.alarm_enabled    <= n_en;
        end
    end

endmodule

### rtl/core/bac_chk.sv
// Port-level checks for bcd_alarm_clock_core, attached by bind.
// Depends on bac_pkg.
module bac_chk
    import bac_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_word i_out_data
);

    logic r_seen_tvalid;

    // Remember that a delivered word already reported a valid time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_tvalid <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_data.time_valid) begin
            r_seen_tvalid <= 1'b1;
        end
    end

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result word changed while stalled");

    a_fire_stop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.alarm_fire && i_out_data.alarm_stop))
        else $error("alarm fire and stop in one word");

    a_fire_on_minute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.alarm_fire |->
            i_out_data.alarm_enabled && i_out_data.out_second_tens == '0 &&
            i_out_data.out_second_units == '0 && i_out_data.tick_count == '0)
        else $error("alarm fired off a minute boundary or while disabled");

    a_tvalid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_tvalid |-> i_out_data.time_valid)
        else $error("time valid dropped after being set");

endmodule

bind bcd_alarm_clock_core bac_chk u_bac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res_ch.valid),
    .i_out_ready (o_res_ch.ready),
    .i_out_data  (o_res_ch.data)
);
